[hdl/tpbp_pkg.sv]
// ----------------------------------------------------------------------------
// tpbp_pkg
// Shared types and constants of the tiered priority buffer pool.
// ----------------------------------------------------------------------------
package tpbp_pkg;

    // Default depth of the free-stack memory
    localparam int POOL_SIZE_DEF = 256;

    localparam int TIERS   = 4;
    localparam int CNT_W   = 9;   // tier sizes, counts, bases
    localparam int IDX_W   = 8;   // buffer index
    localparam int RATIO_W = 7;   // percentage registers
    localparam int PCT_FULL = 100;
    localparam int MIN_SPREAD_TOTAL = 4;

    // floor(p / 100) as (p * DIV100_MUL) >> DIV100_SHIFT, exact for p < 2**16
    localparam int DIV100_MUL   = 83887;
    localparam int DIV100_SHIFT = 23;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef cnt_t [TIERS-1:0] tier_vec_t;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_ACQUIRE = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_REBUILD = 2'd2
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_INVALID   = 2'd2,
        STAT_OVERFLOW  = 2'd3
    } status_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TOTAL    = 3'd0,
        CFG_RT_RATIO = 3'd1,
        CFG_HI_RATIO = 3'd2,
        CFG_NM_RATIO = 3'd3,
        CFG_BORROW   = 3'd4
    } cfg_reg_t;

endpackage

[hdl/tpbp_stack_mem.sv]
// ----------------------------------------------------------------------------
// tpbp_stack_mem
// Single-port free-stack memory, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module tpbp_stack_mem #(
    parameter int DEPTH = tpbp_pkg::POOL_SIZE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               addr,
    input  logic [tpbp_pkg::IDX_W-1:0]  wdata,
    output logic [tpbp_pkg::IDX_W-1:0]  rdata
);

    logic [tpbp_pkg::IDX_W-1:0] mem [DEPTH];
    logic [tpbp_pkg::IDX_W-1:0] rdata_reg;

    // Write port and read-first registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/tpbp_sizer.sv]
// ----------------------------------------------------------------------------
// tpbp_sizer
// Works out the four tier sizes from the total and the percentage ratios,
// one multiply or one tier adjustment per cycle.
// ----------------------------------------------------------------------------
module tpbp_sizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  tpbp_pkg::cnt_t                total,
    input  logic [tpbp_pkg::RATIO_W-1:0]  ratio_rt,
    input  logic [tpbp_pkg::RATIO_W-1:0]  ratio_hi,
    input  logic [tpbp_pkg::RATIO_W-1:0]  ratio_nm,
    output logic                          done,
    output tpbp_pkg::tier_vec_t           sizes
);

    localparam int SZ_W   = tpbp_pkg::CNT_W + 1;  // floor results can pass total
    localparam int SUM_W  = SZ_W + 2;
    localparam int PROD_W = tpbp_pkg::CNT_W + tpbp_pkg::RATIO_W;
    localparam int MK_W   = PROD_W + 18;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_MIN   = 8'b0000_1000,
        S_SUM   = 8'b0001_0000,
        S_TRIM1 = 8'b0010_0000,
        S_TRIM2 = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } sz_state_t;

    sz_state_t               state_reg;
    logic [1:0]              idx_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [SZ_W-1:0]         sz_reg [tpbp_pkg::TIERS];
    logic [SUM_W-1:0]        excess_reg;

    logic [tpbp_pkg::RATIO_W-1:0] ratio_arr [tpbp_pkg::TIERS];
    logic [8:0]              ratio_sum;
    logic [MK_W-1:0]         prod_k;
    logic [1:0]              mx;
    logic [SUM_W-1:0]        sum_all;
    logic [SUM_W-1:0]        sz_cur;
    logic [SUM_W-1:0]        take1;
    logic [SUM_W-1:0]        take2;

    // Ratios; background gets what is left of 100, or nothing
    always_comb begin
        ratio_sum = 9'(ratio_rt) + 9'(ratio_hi) + 9'(ratio_nm);
        ratio_arr[0] = ratio_rt;
        ratio_arr[1] = ratio_hi;
        ratio_arr[2] = ratio_nm;
        ratio_arr[3] = (ratio_sum > 9'(tpbp_pkg::PCT_FULL)) ? '0
                     : tpbp_pkg::RATIO_W'(9'(tpbp_pkg::PCT_FULL) - ratio_sum);
    end

    // Divide by 100 through the reciprocal
    assign prod_k = MK_W'(prod_reg) * MK_W'(tpbp_pkg::DIV100_MUL);

    // First largest tier
    always_comb begin
        mx = 2'd0;
        for (int j = 1; j < tpbp_pkg::TIERS; j++) begin
            if (sz_reg[j] > sz_reg[mx]) begin
                mx = 2'(j);
            end
        end
    end

    // Sum and trim amounts
    always_comb begin
        sum_all = SUM_W'(sz_reg[0]) + SUM_W'(sz_reg[1])
                + SUM_W'(sz_reg[2]) + SUM_W'(sz_reg[3]);
        sz_cur  = SUM_W'(sz_reg[idx_reg]);
        take1   = '0;
        if (sz_cur > SUM_W'(1)) begin
            take1 = ((sz_cur - SUM_W'(1)) > excess_reg) ? excess_reg
                                                        : (sz_cur - SUM_W'(1));
        end
        take2 = (sz_cur > excess_reg) ? excess_reg : sz_cur;
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    idx_reg <= '0;
                    if (start) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= PROD_W'(total) * PROD_W'(ratio_arr[idx_reg]);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    sz_reg[idx_reg] <= prod_k[tpbp_pkg::DIV100_SHIFT +: SZ_W];
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        state_reg <= (total >= tpbp_pkg::cnt_t'(tpbp_pkg::MIN_SPREAD_TOTAL))
                                   ? S_MIN : S_SUM;
                    end else begin
                        state_reg <= S_MUL;
                    end
                end
                S_MIN: begin
                    // empty tier borrows one buffer from the first largest
                    if (sz_reg[idx_reg] == '0 && sz_reg[mx] > SZ_W'(1)) begin
                        sz_reg[mx]      <= sz_reg[mx] - SZ_W'(1);
                        sz_reg[idx_reg] <= SZ_W'(1);
                    end
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (sum_all < SUM_W'(total)) begin
                        sz_reg[0]  <= SZ_W'(SUM_W'(sz_reg[0]) + SUM_W'(total) - sum_all);
                        excess_reg <= '0;
                    end else begin
                        excess_reg <= sum_all - SUM_W'(total);
                    end
                    idx_reg   <= '0;
                    state_reg <= S_TRIM1;
                end
                S_TRIM1: begin
                    // keep at least one buffer in each tier
                    sz_reg[idx_reg] <= SZ_W'(sz_cur - take1);
                    excess_reg      <= excess_reg - take1;
                    idx_reg         <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        state_reg <= S_TRIM2;
                    end
                end
                S_TRIM2: begin
                    // only reached with something left when total is below four
                    sz_reg[idx_reg] <= SZ_W'(sz_cur - take2);
                    excess_reg      <= excess_reg - take2;
                    idx_reg         <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done = (state_reg == S_DONE);

    always_comb begin
        for (int i = 0; i < tpbp_pkg::TIERS; i++) begin
            sizes[i] = tpbp_pkg::cnt_t'(sz_reg[i]);
        end
    end

endmodule

[hdl/tiered_priority_buffer_pool.sv]
// ----------------------------------------------------------------------------
// tiered_priority_buffer_pool
// Buffer index allocator with four priority tiers, each a LIFO free stack
// kept in one slice of a shared stack memory.
// ----------------------------------------------------------------------------
// Acquire, release and unused kinds: the accepting cycle makes the one
// stack-memory access and the count update, and the response state then
// registers the result word. A rebuild runs the sizing sequencer (one multiply
// or one tier adjustment per cycle) and then writes one stack entry per
// cycle through the single memory port. One item is in progress at a time;
// the result register lets the next word be accepted in the cycle its
// predecessor's result is taken. The stack memory is not cleared after reset;
// every tier is empty until the first rebuild, which writes every entry that
// can be popped.
// ----------------------------------------------------------------------------
module tiered_priority_buffer_pool #(
    parameter int POOL_SIZE = tpbp_pkg::POOL_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_wdata,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [1:0]  s_priority_req,
    input  logic [7:0]  s_buffer_index,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_granted_index,
    output logic [8:0]  m_tier_capacity,
    output logic [8:0]  m_tier_available
);

    localparam int AW = $clog2(POOL_SIZE);
    localparam int T  = tpbp_pkg::TIERS;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SIZE = 4'b0010,
        ST_FILL = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    // Configuration registers
    tpbp_pkg::cnt_t              total_reg;
    logic [tpbp_pkg::RATIO_W-1:0] rt_ratio_reg;
    logic [tpbp_pkg::RATIO_W-1:0] hi_ratio_reg;
    logic [tpbp_pkg::RATIO_W-1:0] nm_ratio_reg;
    logic                        borrow_reg;

    // Tier state
    tpbp_pkg::tier_vec_t size_reg;
    tpbp_pkg::tier_vec_t base_reg;
    tpbp_pkg::tier_vec_t count_reg;
    tpbp_pkg::tier_vec_t end_w;

    // Control and item registers
    state_t               state_reg;
    tpbp_pkg::cnt_t       pos_reg;
    logic [1:0]           pr_reg;
    tpbp_pkg::status_t    status_reg;
    logic                 grant_reg;
    logic [7:0]           gbase_reg;

    // Result register
    logic                 m_valid_reg;
    tpbp_pkg::status_t    m_status_reg;
    logic [7:0]           m_granted_reg;
    tpbp_pkg::cnt_t       m_cap_reg;
    tpbp_pkg::cnt_t       m_avail_reg;

    logic                 accept;
    tpbp_pkg::cnt_t       total_sat;
    logic                 acq_found;
    logic [1:0]           acq_tier;
    logic                 rel_in_range;
    logic [1:0]           rel_tier;
    logic [1:0]           fill_tier;
    logic                 fill_busy;
    logic                 mem_we;
    tpbp_pkg::cnt_t       mem_addr_w;
    logic [7:0]           mem_wdata;
    logic [7:0]           mem_rdata;
    logic                 sizer_start;
    logic                 sizer_done;
    tpbp_pkg::tier_vec_t  sizer_sizes;

    // First tier whose end lies above v
    function automatic logic [1:0] tier_of(input tpbp_pkg::cnt_t v,
                                           input tpbp_pkg::tier_vec_t ends);
        logic [1:0] t;
        t = 2'd3;
        for (int i = T - 1; i >= 0; i--) begin
            if (v < ends[i]) begin
                t = 2'(i);
            end
        end
        return t;
    endfunction

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= 9'd256;
            rt_ratio_reg <= 7'd25;
            hi_ratio_reg <= 7'd25;
            nm_ratio_reg <= 7'd25;
            borrow_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tpbp_pkg::CFG_TOTAL:    total_reg    <= cfg_wdata;
                tpbp_pkg::CFG_RT_RATIO: rt_ratio_reg <= cfg_wdata[tpbp_pkg::RATIO_W-1:0];
                tpbp_pkg::CFG_HI_RATIO: hi_ratio_reg <= cfg_wdata[tpbp_pkg::RATIO_W-1:0];
                tpbp_pkg::CFG_NM_RATIO: nm_ratio_reg <= cfg_wdata[tpbp_pkg::RATIO_W-1:0];
                tpbp_pkg::CFG_BORROW:   borrow_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign total_sat = (32'(total_reg) > POOL_SIZE) ? tpbp_pkg::cnt_t'(POOL_SIZE)
                                                    : total_reg;

    // Tier ends
    always_comb begin
        for (int i = 0; i < T; i++) begin
            end_w[i] = base_reg[i] + size_reg[i];
        end
    end

    // Acquire: own tier first, then lower priorities when borrowing
    always_comb begin
        acq_found = 1'b0;
        acq_tier  = s_priority_req;
        for (int t = 0; t < T; t++) begin
            if (!acq_found && 2'(t) >= s_priority_req
                && (2'(t) == s_priority_req || borrow_reg)
                && count_reg[t] != '0) begin
                acq_found = 1'b1;
                acq_tier  = 2'(t);
            end
        end
    end

    // Release: range check and owning tier
    assign rel_in_range = {1'b0, s_buffer_index} < end_w[T-1];
    assign rel_tier     = tier_of({1'b0, s_buffer_index}, end_w);

    // Refill walk
    assign fill_tier = tier_of(pos_reg, end_w);
    assign fill_busy = (state_reg == ST_FILL) && (pos_reg != end_w[T-1]);

    // Stack memory port
    always_comb begin
        mem_we     = 1'b0;
        mem_addr_w = '0;
        mem_wdata  = '0;
        if (fill_busy) begin
            mem_we     = 1'b1;
            mem_addr_w = pos_reg;
            mem_wdata  = 8'(end_w[fill_tier] - 9'd1 - pos_reg);
        end else if (accept && s_kind == tpbp_pkg::KIND_RELEASE) begin
            mem_we     = rel_in_range && (count_reg[rel_tier] < size_reg[rel_tier]);
            mem_addr_w = base_reg[rel_tier] + count_reg[rel_tier];
            mem_wdata  = 8'({1'b0, s_buffer_index} - base_reg[rel_tier]);
        end else if (accept && s_kind == tpbp_pkg::KIND_ACQUIRE) begin
            mem_addr_w = base_reg[acq_tier] + count_reg[acq_tier] - 9'd1;
        end
    end

    tpbp_stack_mem #(
        .DEPTH (POOL_SIZE),
        .AW    (AW)
    ) u_stack (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (AW'(mem_addr_w)),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign sizer_start = accept && s_kind == tpbp_pkg::KIND_REBUILD;

    tpbp_sizer u_sizer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sizer_start),
        .total    (total_sat),
        .ratio_rt (rt_ratio_reg),
        .ratio_hi (hi_ratio_reg),
        .ratio_nm (nm_ratio_reg),
        .done     (sizer_done),
        .sizes    (sizer_sizes)
    );

    // Main sequencer and tier bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            size_reg  <= '0;
            base_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        pr_reg    <= s_priority_req;
                        grant_reg <= (s_kind == tpbp_pkg::KIND_ACQUIRE) && acq_found;
                        state_reg <= (s_kind == tpbp_pkg::KIND_REBUILD) ? ST_SIZE
                                                                        : ST_RESP;
                        if (s_kind == tpbp_pkg::KIND_ACQUIRE) begin
                            if (acq_found) begin
                                count_reg[acq_tier] <= count_reg[acq_tier] - 9'd1;
                                gbase_reg  <= base_reg[acq_tier][7:0];
                                status_reg <= tpbp_pkg::STAT_OK;
                            end else begin
                                status_reg <= tpbp_pkg::STAT_EXHAUSTED;
                            end
                        end else if (s_kind == tpbp_pkg::KIND_RELEASE) begin
                            if (!rel_in_range) begin
                                status_reg <= tpbp_pkg::STAT_INVALID;
                            end else if (count_reg[rel_tier] >= size_reg[rel_tier]) begin
                                status_reg <= tpbp_pkg::STAT_OVERFLOW;
                            end else begin
                                count_reg[rel_tier] <= count_reg[rel_tier] + 9'd1;
                                status_reg <= tpbp_pkg::STAT_OK;
                            end
                        end else begin
                            status_reg <= tpbp_pkg::STAT_OK;
                        end
                    end
                end
                ST_SIZE: begin
                    if (sizer_done) begin
                        size_reg    <= sizer_sizes;
                        count_reg   <= sizer_sizes;
                        base_reg[0] <= '0;
                        base_reg[1] <= sizer_sizes[0];
                        base_reg[2] <= sizer_sizes[0] + sizer_sizes[1];
                        base_reg[3] <= sizer_sizes[0] + sizer_sizes[1] + sizer_sizes[2];
                        pos_reg     <= '0;
                        state_reg   <= ST_FILL;
                    end
                end
                ST_FILL: begin
                    // lowest index of each tier lands on top of its stack
                    if (fill_busy) begin
                        pos_reg <= pos_reg + 9'd1;
                    end else begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_RESP) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RESP) begin
            m_status_reg  <= status_reg;
            m_granted_reg <= grant_reg ? (gbase_reg + mem_rdata) : 8'd0;
            m_cap_reg     <= size_reg[pr_reg];
            m_avail_reg   <= count_reg[pr_reg];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_granted_index  = m_granted_reg;
    assign m_tier_capacity  = m_cap_reg;
    assign m_tier_available = m_avail_reg;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tiered priority buffer pool. A shadow copy of
// the tier sizing, the per-tier LIFO stacks and the counts predicts every
// result word. Directed tests cover the empty pool, the default split, the
// borrow chain and sizing corners. Random phases then run allocate/free
// traffic under several register settings, with random gaps and stalls on
// both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] TIER_RT = 2'd0;
    localparam logic [1:0] TIER_HI = 2'd1;
    localparam logic [1:0] TIER_NM = 2'd2;
    localparam logic [1:0] TIER_BG = 2'd3;
    localparam int STACK_DEPTH = 256;

    typedef struct packed {
        tpbp_pkg::status_t status;
        logic [7:0]        granted;
        tpbp_pkg::cnt_t    capacity;
        tpbp_pkg::cnt_t    available;
    } pool_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [1:0]  s_priority_req;
    logic [7:0]  s_buffer_index;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_granted_index;
    logic [8:0]  m_tier_capacity;
    logic [8:0]  m_tier_available;

    // shadow registers
    logic [8:0] cfg_total;
    logic [6:0] cfg_ratio [3];
    logic       cfg_borrow;

    // shadow pool state
    logic [7:0]     stack_mem [STACK_DEPTH];
    tpbp_pkg::cnt_t free_cnt [tpbp_pkg::TIERS];
    tpbp_pkg::cnt_t tier_sz [tpbp_pkg::TIERS];
    tpbp_pkg::cnt_t tier_base [tpbp_pkg::TIERS];

    pool_result_t pending_results [$];
    pool_result_t due;
    logic [7:0]   held_bufs [$];
    int unsigned  mismatches = 0;
    int unsigned  ready_hold = 0;
    bit           quiet;

    tiered_priority_buffer_pool i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_priority_req   (s_priority_req),
        .s_buffer_index   (s_buffer_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_granted_index  (m_granted_index),
        .m_tier_capacity  (m_tier_capacity),
        .m_tier_available (m_tier_available)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // tier sizing and stack refill
    function automatic void rebuild_tiers();
        int total, rsum, excess, take, mx, off;
        int ratio [4];
        int sz [4];
        total = (cfg_total > STACK_DEPTH) ? STACK_DEPTH : int'(cfg_total);
        for (int i = 0; i < 3; i++)
            ratio[i] = cfg_ratio[i];
        rsum = ratio[0] + ratio[1] + ratio[2];
        ratio[3] = (rsum > tpbp_pkg::PCT_FULL) ? 0 : tpbp_pkg::PCT_FULL - rsum;
        for (int i = 0; i < tpbp_pkg::TIERS; i++)
            sz[i] = (total * ratio[i]) / tpbp_pkg::PCT_FULL;

        // every empty tier takes one from the first largest
        if (total >= tpbp_pkg::MIN_SPREAD_TOTAL) begin
            for (int i = 0; i < tpbp_pkg::TIERS; i++) begin
                if (sz[i] == 0) begin
                    mx = 0;
                    for (int j = 1; j < tpbp_pkg::TIERS; j++)
                        if (sz[j] > sz[mx]) mx = j;
                    if (sz[mx] > 1) begin
                        sz[mx]--;
                        sz[i]++;
                    end
                end
            end
        end

        // settle the sum on total
        rsum = sz[0] + sz[1] + sz[2] + sz[3];
        if (rsum < total) begin
            sz[0] += total - rsum;
        end else if (rsum > total) begin
            excess = rsum - total;
            for (int i = 0; i < tpbp_pkg::TIERS && excess > 0; i++) begin
                if (sz[i] > 1) begin
                    take = sz[i] - 1;
                    if (take > excess) take = excess;
                    sz[i] -= take;
                    excess -= take;
                end
            end
            for (int i = 0; i < tpbp_pkg::TIERS && excess > 0; i++) begin
                take = (sz[i] > excess) ? excess : sz[i];
                sz[i] -= take;
                excess -= take;
            end
        end

        // refill so that the lowest index pops first
        off = 0;
        for (int i = 0; i < tpbp_pkg::TIERS; i++) begin
            tier_sz[i] = tpbp_pkg::cnt_t'(sz[i]);
            tier_base[i] = tpbp_pkg::cnt_t'(off);
            for (int j = 0; j < sz[i]; j++)
                stack_mem[off + j] = 8'(sz[i] - 1 - j);
            free_cnt[i] = tpbp_pkg::cnt_t'(sz[i]);
            off += sz[i];
        end
    endfunction

    function automatic bit pop_tier(input int t, output logic [7:0] buf_idx);
        int pos;
        buf_idx = '0;
        if (free_cnt[t] == 0)
            return 1'b0;
        free_cnt[t]--;
        pos = tier_base[t] + free_cnt[t];
        buf_idx = 8'(tier_base[t] + stack_mem[pos]);
        return 1'b1;
    endfunction

    // work out the result word of one accepted item
    function automatic void apply_pool_op(input logic [1:0] kind, input logic [1:0] prio,
                                          input logic [7:0] idx);
        pool_result_t r;
        logic [7:0] g;
        bit got;
        int t, lo, pos;
        r = '0;
        r.status = tpbp_pkg::STAT_OK;
        case (kind)
            tpbp_pkg::KIND_ACQUIRE: begin
                got = pop_tier(prio, g);
                for (int k = prio + 1; k < tpbp_pkg::TIERS && !got && cfg_borrow; k++)
                    got = pop_tier(k, g);
                if (got) begin
                    r.granted = g;
                    held_bufs.push_back(g);
                end else begin
                    r.status = tpbp_pkg::STAT_EXHAUSTED;
                end
            end
            tpbp_pkg::KIND_RELEASE: begin
                if (idx >= tier_base[3] + tier_sz[3]) begin
                    r.status = tpbp_pkg::STAT_INVALID;
                end else begin
                    t = 0;
                    lo = 0;
                    for (int i = 0; i < tpbp_pkg::TIERS; i++) begin
                        if (idx < lo + tier_sz[i]) begin
                            t = i;
                            break;
                        end
                        lo += tier_sz[i];
                    end
                    if (free_cnt[t] >= tier_sz[t]) begin
                        r.status = tpbp_pkg::STAT_OVERFLOW;
                    end else begin
                        pos = tier_base[t] + free_cnt[t];
                        stack_mem[pos] = 8'(idx - tier_base[t]);
                        free_cnt[t]++;
                    end
                end
            end
            tpbp_pkg::KIND_REBUILD: begin
                rebuild_tiers();
                held_bufs.delete();
            end
            default: ;
        endcase
        r.capacity = tier_sz[prio];
        r.available = free_cnt[prio];
        pending_results.push_back(r);
    endfunction

    // send one word; s_valid stays high for a back-to-back successor
    task automatic send_word(input logic [1:0] kind, input logic [1:0] prio,
                             input logic [7:0] idx);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_priority_req <= prio;
        s_buffer_index <= idx;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        apply_pool_op(kind, prio, idx);
    endtask

    // hold off until every result word is back
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [8:0] total, input logic [6:0] rt,
                              input logic [6:0] hi, input logic [6:0] nm, input logic en);
        logic [8:0] vals [5];
        vals = '{total, {2'b00, rt}, {2'b00, hi}, {2'b00, nm}, {8'd0, en}};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= tpbp_pkg::cfg_reg_t'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        cfg_total    = total;
        cfg_ratio[0] = rt;
        cfg_ratio[1] = hi;
        cfg_ratio[2] = nm;
        cfg_borrow   = en;
    endtask

    // empty pool: nothing to grant, nothing in range
    task automatic test_before_rebuild();
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_RT, 8'd0);
        send_word(tpbp_pkg::KIND_RELEASE, TIER_HI, 8'd5);
        send_word(KIND_UNUSED, TIER_BG, 8'hFF);
    endtask

    // reset split of 64 per tier; re-push of a free buffer, then overflow
    task automatic test_default_tiers();
        send_word(tpbp_pkg::KIND_REBUILD, TIER_BG, 8'd0);
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_RT, 8'h00);
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_RT, 8'hFF);
        send_word(tpbp_pkg::KIND_RELEASE, TIER_RT, 8'd1);
        send_word(tpbp_pkg::KIND_RELEASE, TIER_RT, 8'd1);
        send_word(tpbp_pkg::KIND_RELEASE, TIER_RT, 8'd0);
        send_word(tpbp_pkg::KIND_RELEASE, TIER_BG, 8'd255);
    endtask

    // one buffer per tier; acquire walks down the tiers only with borrow on
    task automatic test_borrow_chain();
        drain();
        set_config(9'd4, 7'd100, 7'd0, 7'd0, 1'b1);
        send_word(tpbp_pkg::KIND_REBUILD, TIER_RT, 8'd0);
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_RT, 8'd0);
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_RT, 8'd0);
        drain();
        set_config(9'd4, 7'd100, 7'd0, 7'd0, 1'b0);
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_RT, 8'd0);
        drain();
        set_config(9'd4, 7'd100, 7'd0, 7'd0, 1'b1);
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_BG, 8'd0);
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_BG, 8'd0);
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_NM, 8'd0);
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_RT, 8'd0);
    endtask

    // zero total, tiny totals, oversized total, ratio sum above 100
    task automatic test_sizing_corners();
        drain();
        set_config(9'd0, 7'd25, 7'd25, 7'd25, 1'b1);
        send_word(tpbp_pkg::KIND_REBUILD, TIER_RT, 8'd0);
        send_word(tpbp_pkg::KIND_RELEASE, TIER_RT, 8'd0);
        drain();
        set_config(9'd3, 7'd0, 7'd0, 7'd0, 1'b1);
        send_word(tpbp_pkg::KIND_REBUILD, TIER_BG, 8'd0);
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_HI, 8'd0);
        drain();
        set_config(9'd511, 7'd50, 7'd50, 7'd50, 1'b1);
        send_word(tpbp_pkg::KIND_REBUILD, TIER_HI, 8'd0);
        drain();
        // leftover excess with total below four: trimmed to zero
        set_config(9'd1, 7'd100, 7'd100, 7'd100, 1'b1);
        send_word(tpbp_pkg::KIND_REBUILD, TIER_NM, 8'd0);
        send_word(tpbp_pkg::KIND_ACQUIRE, TIER_RT, 8'd0);
    endtask

    // allocate/free traffic under random settings
    task automatic test_random_traffic();
        logic [8:0] total;
        logic [6:0] rt, hi, nm;
        int unsigned r, pick;
        logic [7:0] idx;
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            r = $urandom_range(0, 9);
            if (phase == 0)
                total = 9'd256;
            else if (r == 0)
                total = 9'($urandom_range(0, 3));
            else if (r == 1)
                total = 9'($urandom_range(257, 511));
            else
                total = 9'($urandom_range(4, 256));
            if ($urandom_range(0, 1) == 0) begin
                rt = 7'($urandom_range(0, 40));
                hi = 7'($urandom_range(0, 40));
                nm = 7'($urandom_range(0, 20));
            end else begin
                rt = 7'($urandom_range(0, 100));
                hi = 7'($urandom_range(0, 100));
                nm = 7'($urandom_range(0, 100));
            end
            set_config(total, rt, hi, nm, 1'($urandom_range(0, 1)));
            quiet = (phase == 2);
            send_word(tpbp_pkg::KIND_REBUILD, 2'($urandom), 8'($urandom));
            for (int n = 0; n < 250; n++) begin
                r = $urandom_range(0, 99);
                if (r < 45 || (r < 80 && held_bufs.size() == 0)) begin
                    send_word(tpbp_pkg::KIND_ACQUIRE, 2'($urandom), 8'($urandom));
                end else if (r < 80) begin
                    pick = $urandom_range(0, held_bufs.size() - 1);
                    idx = held_bufs[pick];
                    held_bufs.delete(pick);
                    send_word(tpbp_pkg::KIND_RELEASE, 2'($urandom), idx);
                end else if (r < 92) begin
                    send_word(tpbp_pkg::KIND_RELEASE, 2'($urandom), 8'($urandom));
                end else if (r < 96) begin
                    send_word(tpbp_pkg::KIND_REBUILD, 2'($urandom), 8'($urandom));
                end else begin
                    send_word(KIND_UNUSED, 2'($urandom), 8'($urandom));
                end
            end
            quiet = 1'b0;
        end
    endtask

    task automatic report_field(input string field, input logic [8:0] want,
                                input logic [8:0] got);
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
            ready_hold = gap_len();
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected, status %0d",
                         $time, m_status);
                mismatches++;
            end else begin
                due = pending_results.pop_front();
                if (m_status !== due.status)
                    report_field("status", 9'(due.status), 9'(m_status));
                if (m_granted_index !== due.granted)
                    report_field("granted_index", 9'(due.granted), 9'(m_granted_index));
                if (m_tier_capacity !== due.capacity)
                    report_field("tier_capacity", due.capacity, m_tier_capacity);
                if (m_tier_available !== due.available)
                    report_field("tier_available", due.available, m_tier_available);
            end
        end
    end

    initial begin
        #(30_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_kind         = '0;
        s_priority_req = '0;
        s_buffer_index = '0;
        quiet          = 1'b0;
        cfg_total      = 9'd256;
        cfg_ratio      = '{7'd25, 7'd25, 7'd25};
        cfg_borrow     = 1'b1;
        for (int i = 0; i < tpbp_pkg::TIERS; i++) begin
            free_cnt[i]  = '0;
            tier_sz[i]   = '0;
            tier_base[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_before_rebuild();
        test_default_tiers();
        test_borrow_chain();
        test_sizing_corners();
        test_random_traffic();

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
